// File: rtl/lbd_pkg.sv
// Shared types, codes and fixed-point helpers of the D1Q3 heat-diffusion lattice.
`default_nettype none
package lbd_pkg;

    localparam int LAT = 8;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] BND_FIXED = 2'd0;
    localparam logic [1:0] BND_FLUX  = 2'd1;

    localparam logic [2:0] REG_OMEGA  = 3'd0;
    localparam logic [2:0] REG_W_REST = 3'd1;
    localparam logic [2:0] REG_W_MOVE = 3'd2;
    localparam logic [2:0] REG_SOURCE = 3'd3;
    localparam logic [2:0] REG_L_MODE = 3'd4;
    localparam logic [2:0] REG_L_VAL  = 3'd5;
    localparam logic [2:0] REG_R_MODE = 3'd6;
    localparam logic [2:0] REG_R_VAL  = 3'd7;

    localparam logic signed [39:0] SAT_MAX = 40'sd2147483647;
    localparam logic signed [39:0] SAT_MIN = -40'sd2147483648;

    typedef struct packed {
        logic [31:0] rest;
        logic [31:0] right;
        logic [31:0] left;
        logic [31:0] temp;
    } rec_t;

    typedef struct packed {
        logic [17:0] omega;
        logic [16:0] w0;
        logic [16:0] w1;
        logic [31:0] source;
        logic [1:0]  lmode;
        logic [31:0] lval;
        logic [1:0]  rmode;
        logic [31:0] rval;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic v_head;
        logic v_p2;
        logic c1_first;
        logic c1_last;
        logic f1_first;
        logic f1_last;
        logic v_g;
    } ctl_t;

    function automatic logic signed [34:0] qmul(input logic signed [18:0] a,
                                                input logic signed [31:0] b);
        logic signed [50:0] p;
        p = 51'(a) * 51'(b) + 51'sd32768;
        return p[50:16];
    endfunction

    function automatic logic ovf(input logic signed [39:0] v);
        return (v > SAT_MAX) || (v < SAT_MIN);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lattice_boltzmann_d1q3_heat_step.sv
// Top level of the D1Q3 lattice Boltzmann heat-diffusion block.
// Every load, step or read request keeps busy high from the accepting edge until the ring
// has turned once (an unused mode code is ignored and leaves busy low): the prep state forms
// the load values or the source terms, then the ring of NODES node cells and the eight
// processing stages rotates once, and each node passes collision, streaming, boundary and
// temperature on its way round. A read result is shown in the cycle in which busy falls, with
// done high for that one cycle; it cannot be held off. The node stores need no clearing after reset.
`default_nettype none
module lattice_boltzmann_d1q3_heat_step #(
    parameter int NODES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [7:0]  node,
    input  wire logic [31:0] temperature,
    output logic             done,
    output logic [7:0]       node_out,
    output logic [31:0]      temperature_out,
    output logic             saturated,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import lbd_pkg::*;

    localparam int RUN_LEN = NODES + LAT;
    localparam int CW      = $clog2(RUN_LEN + 1);
    localparam int MW      = (CW > 8) ? CW : 8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PREP = 3'b010,
        ST_RUN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]  mode_reg;
    logic [7:0]  node_reg;
    logic [31:0] t_reg;
    logic [31:0] a_reg, b_reg;
    logic [31:0] rd_temp_reg;
    logic flag_reg, flag_next;
    logic done_reg, done_next;
    logic [7:0]  node_out_reg;
    logic [31:0] temp_out_reg;
    logic sat_out_reg;

    cfg_t cfg_reg;
    ctl_t ctl;

    logic accept, run, last, node_ok, node_hit;
    logic signed [31:0] px;
    logic signed [34:0] pa, pb;
    logic prep_sat, col_sat, str_sat;
    rec_t ring [NODES];
    rec_t h_rec, load_rec;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);
    assign run    = (state_reg == ST_RUN);
    assign last   = run && (cnt_reg == CW'(RUN_LEN - 1));
    assign node_ok  = (MW'(node_reg) < MW'(NODES));
    assign node_hit = ctl.v_head && (MW'(cnt_reg) == MW'(node_reg));

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.omega  <= 18'd65536;
            cfg_reg.w0     <= 17'd43691;
            cfg_reg.w1     <= 17'd10923;
            cfg_reg.source <= 32'd0;
            cfg_reg.lmode  <= 2'd2;
            cfg_reg.lval   <= 32'd0;
            cfg_reg.rmode  <= 2'd2;
            cfg_reg.rval   <= 32'd0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_OMEGA:  cfg_reg.omega  <= pwdata[17:0];
                REG_W_REST: cfg_reg.w0     <= pwdata[16:0];
                REG_W_MOVE: cfg_reg.w1     <= pwdata[16:0];
                REG_SOURCE: cfg_reg.source <= pwdata;
                REG_L_MODE: cfg_reg.lmode  <= pwdata[1:0];
                REG_L_VAL:  cfg_reg.lval   <= pwdata;
                REG_R_MODE: cfg_reg.rmode  <= pwdata[1:0];
                REG_R_VAL:  cfg_reg.rval   <= pwdata;
                default:    cfg_reg.omega  <= cfg_reg.omega;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_OMEGA:  prdata = {14'd0, cfg_reg.omega};
            REG_W_REST: prdata = {15'd0, cfg_reg.w0};
            REG_W_MOVE: prdata = {15'd0, cfg_reg.w1};
            REG_SOURCE: prdata = cfg_reg.source;
            REG_L_MODE: prdata = {30'd0, cfg_reg.lmode};
            REG_L_VAL:  prdata = cfg_reg.lval;
            REG_R_MODE: prdata = {30'd0, cfg_reg.rmode};
            REG_R_VAL:  prdata = cfg_reg.rval;
            default:    prdata = 32'd0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_LOAD || mode == MODE_STEP || mode == MODE_READ))
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
                cnt_next   = '0;
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            flag_reg  <= 1'b0;
            done_reg  <= 1'b0;
            mode_reg  <= MODE_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
            done_reg  <= done_next;
            if (accept)
            begin
                mode_reg <= mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg    <= node;
            t_reg       <= temperature;
            rd_temp_reg <= 32'd0;
        end
        else if (run && mode_reg == MODE_READ && node_hit)
        begin
            rd_temp_reg <= ring[0].temp;
        end
        if (state_reg == ST_PREP)
        begin
            a_reg <= sat32(40'(pa));
            b_reg <= sat32(40'(pb));
        end
        if (done_next)
        begin
            node_out_reg <= node_reg;
            temp_out_reg <= rd_temp_reg;
            sat_out_reg  <= flag_reg;
        end
    end

    // source terms for a step, equilibrium values for a load
    assign px = (mode_reg == MODE_STEP) ? $signed(cfg_reg.source) : $signed(t_reg);
    assign pa = qmul($signed({2'b00, cfg_reg.w0}), px);
    assign pb = qmul($signed({2'b00, cfg_reg.w1}), px);
    assign prep_sat = (state_reg == ST_PREP)
                   && ((mode_reg == MODE_STEP) || (mode_reg == MODE_LOAD && node_ok))
                   && (ovf(40'(pa)) || ovf(40'(pb)));

    assign done_next = last && (mode_reg == MODE_READ);

    always_comb
    begin
        flag_next = flag_reg || prep_sat || (run && (col_sat || str_sat));
        if (done_next)
        begin
            flag_next = 1'b0;
        end
    end

    // stage validity along the ring
    assign ctl.step     = (mode_reg == MODE_STEP);
    assign ctl.v_head   = (cnt_reg < CW'(NODES));
    assign ctl.v_p2     = (cnt_reg >= CW'(2)) && (cnt_reg < CW'(NODES + 2));
    assign ctl.c1_first = (cnt_reg == CW'(4));
    assign ctl.c1_last  = (cnt_reg == CW'(NODES + 3));
    assign ctl.f1_first = (cnt_reg == CW'(6));
    assign ctl.f1_last  = (cnt_reg == CW'(NODES + 5));
    assign ctl.v_g      = (cnt_reg >= CW'(7)) && (cnt_reg < CW'(NODES + 7));

    assign load_rec.rest  = a_reg;
    assign load_rec.right = b_reg;
    assign load_rec.left  = b_reg;
    assign load_rec.temp  = t_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_ring
            if (gi == NODES - 1)
            begin : g_tail
                lbd_cell u_cell (.clk(clk), .shift(run), .d(h_rec), .q(ring[gi]));
            end
            else
            begin : g_body
                lbd_cell u_cell (.clk(clk), .shift(run), .d(ring[gi+1]), .q(ring[gi]));
            end
        end
    endgenerate

    rec_t c0_rec;

    lbd_collide u_collide (
        .clk      (clk),
        .en       (run),
        .ctl      (ctl),
        .cfg      (cfg_reg),
        .src0     (a_reg),
        .src1     (b_reg),
        .head     (ring[0]),
        .inject   ((mode_reg == MODE_LOAD) && node_hit),
        .load_rec (load_rec),
        .c0       (c0_rec),
        .sat      (col_sat)
    );

    lbd_stream u_stream (
        .clk (clk),
        .en  (run),
        .ctl (ctl),
        .cfg (cfg_reg),
        .c0  (c0_rec),
        .h   (h_rec),
        .sat (str_sat)
    );

    assign done            = done_reg;
    assign node_out        = node_out_reg;
    assign temperature_out = temp_out_reg;
    assign saturated       = sat_out_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(state_reg == ST_RUN))
        else $error("result strobe outside the end of a read");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> cnt_reg < CW'(RUN_LEN))
        else $error("ring counter overran the rotation");
    a_prep_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |=> run && cnt_reg == '0)
        else $error("rotation did not start from node zero");
    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_next |=> !flag_reg)
        else $error("saturation flag not cleared by read");
`endif

endmodule
`default_nettype wire

// File: rtl/lbd_cell.sv
// One lattice node cell of the rotating ring: holds the node's distributions and temperature.
`default_nettype none
module lbd_cell (
    input  wire logic         clk,
    input  wire logic         shift,
    input  wire lbd_pkg::rec_t d,
    output lbd_pkg::rec_t     q
);
    import lbd_pkg::*;

    rec_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule
`default_nettype wire

// File: rtl/lbd_collide.sv
// Collision stages of the ring: equilibrium, products, relaxed sums; load injection in pass mode.
`default_nettype none
module lbd_collide (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire lbd_pkg::ctl_t ctl,
    input  wire lbd_pkg::cfg_t cfg,
    input  wire logic [31:0]   src0,
    input  wire logic [31:0]   src1,
    input  wire lbd_pkg::rec_t head,
    input  wire logic          inject,
    input  wire lbd_pkg::rec_t load_rec,
    output lbd_pkg::rec_t      c0,
    output logic               sat
);
    import lbd_pkg::*;

    logic signed [18:0] omega_s, keep_s, w0_s, w1_s;
    logic signed [34:0] feq0_raw, feq1_raw;
    logic [31:0] feq0, feq1;
    logic of0, of1;

    rec_t p1_rec_reg, p1_rec_next;
    logic [31:0] feq0_reg, feq1_reg;
    rec_t p2_rec_reg;
    logic signed [34:0] kr_reg, kp_reg, km_reg, o0_reg, o1_reg;
    rec_t c0_reg, c0_next;

    logic signed [39:0] sum_r, sum_p, sum_m;

    assign omega_s = $signed({1'b0, cfg.omega});
    assign keep_s  = 19'sd65536 - omega_s;
    assign w0_s    = $signed({2'b00, cfg.w0});
    assign w1_s    = $signed({2'b00, cfg.w1});

    assign feq0_raw = qmul(w0_s, $signed(head.temp));
    assign feq1_raw = qmul(w1_s, $signed(head.temp));
    assign feq0 = sat32(40'(feq0_raw));
    assign feq1 = sat32(40'(feq1_raw));
    assign of0  = ovf(40'(feq0_raw));
    assign of1  = ovf(40'(feq1_raw));

    always_comb
    begin
        p1_rec_next = head;
        if (!ctl.step && inject)
        begin
            p1_rec_next = load_rec;
        end
    end

    assign sum_r = 40'(kr_reg) + 40'(o0_reg) + 40'($signed(src0));
    assign sum_p = 40'(kp_reg) + 40'(o1_reg) + 40'($signed(src1));
    assign sum_m = 40'(km_reg) + 40'(o1_reg) + 40'($signed(src1));

    always_comb
    begin
        c0_next = p2_rec_reg;
        if (ctl.step)
        begin
            c0_next.rest  = sat32(sum_r);
            c0_next.right = sat32(sum_p);
            c0_next.left  = sat32(sum_m);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_rec_reg <= p1_rec_next;
            feq0_reg   <= feq0;
            feq1_reg   <= feq1;
            p2_rec_reg <= p1_rec_reg;
            kr_reg     <= qmul(keep_s, $signed(p1_rec_reg.rest));
            kp_reg     <= qmul(keep_s, $signed(p1_rec_reg.right));
            km_reg     <= qmul(keep_s, $signed(p1_rec_reg.left));
            o0_reg     <= qmul(omega_s, $signed(feq0_reg));
            o1_reg     <= qmul(omega_s, $signed(feq1_reg));
            c0_reg     <= c0_next;
        end
    end

    assign sat = ctl.step && ((ctl.v_head && (of0 || of1)) ||
                 (ctl.v_p2 && (ovf(sum_r) || ovf(sum_p) || ovf(sum_m))));
    assign c0  = c0_reg;

endmodule
`default_nettype wire

// File: rtl/lbd_stream.sv
// Streaming, boundary and temperature stages of the ring.
`default_nettype none
module lbd_stream (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire lbd_pkg::ctl_t ctl,
    input  wire lbd_pkg::cfg_t cfg,
    input  wire lbd_pkg::rec_t c0,
    output lbd_pkg::rec_t      h,
    output logic               sat
);
    import lbd_pkg::*;

    rec_t c1_reg, cd_reg, f0_reg, f0_next, f1_reg, fd_reg, g_reg, g_next, h_reg, h_next;
    logic signed [39:0] bl, br, tsum;
    logic bsat;

    always_comb
    begin
        f0_next = c1_reg;
        if (ctl.step)
        begin
            if (!ctl.c1_first)
            begin
                f0_next.right = cd_reg.right;
            end
            if (!ctl.c1_last)
            begin
                f0_next.left = c0.left;
            end
        end
    end

    assign bl = 40'($signed(cfg.lval))
              - (40'($signed(f1_reg.rest)) + 40'($signed(f1_reg.left)))
              + ((cfg.lmode == BND_FLUX)
                 ? (40'($signed(f0_reg.rest)) + 40'($signed(f0_reg.right))
                    + 40'($signed(f0_reg.left)))
                 : 40'sd0);
    assign br = 40'($signed(cfg.rval))
              - (40'($signed(f1_reg.rest)) + 40'($signed(f1_reg.right)))
              + ((cfg.rmode == BND_FLUX)
                 ? (40'($signed(fd_reg.rest)) + 40'($signed(fd_reg.right))
                    + 40'($signed(fd_reg.left)))
                 : 40'sd0);

    always_comb
    begin
        g_next = f1_reg;
        bsat   = 1'b0;
        if (ctl.step && ctl.f1_first)
        begin
            case (cfg.lmode)
                BND_FIXED:
                begin
                    g_next.right = sat32(bl);
                    bsat = ovf(bl);
                end
                BND_FLUX:
                begin
                    if (cfg.lval == 32'd0)
                    begin
                        g_next = f0_reg;
                    end
                    else
                    begin
                        g_next.right = sat32(bl);
                        bsat = ovf(bl);
                    end
                end
                default:
                begin
                    g_next = f1_reg;
                end
            endcase
        end
        else if (ctl.step && ctl.f1_last)
        begin
            case (cfg.rmode)
                BND_FIXED:
                begin
                    g_next.left = sat32(br);
                    bsat = ovf(br);
                end
                BND_FLUX:
                begin
                    if (cfg.rval == 32'd0)
                    begin
                        g_next = fd_reg;
                    end
                    else
                    begin
                        g_next.left = sat32(br);
                        bsat = ovf(br);
                    end
                end
                default:
                begin
                    g_next = f1_reg;
                end
            endcase
        end
    end

    assign tsum = 40'($signed(g_reg.rest)) + 40'($signed(g_reg.right))
                + 40'($signed(g_reg.left));

    always_comb
    begin
        h_next = g_reg;
        if (ctl.step)
        begin
            h_next.temp = sat32(tsum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c0;
            cd_reg <= c1_reg;
            f0_reg <= f0_next;
            f1_reg <= f0_reg;
            fd_reg <= f1_reg;
            g_reg  <= g_next;
            h_reg  <= h_next;
        end
    end

    assign sat = bsat || (ctl.step && ctl.v_g && ovf(tsum));
    assign h   = h_reg;

endmodule
`default_nettype wire
